[design/arc_odometry_pose_update_defines.svh]
// Assertion macros for the arc odometry pose update checker
`ifndef ARC_ODOMETRY_POSE_UPDATE_DEFINES_SVH
`define ARC_ODOMETRY_POSE_UPDATE_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define AOPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define AOPU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/aopu_pkg.sv]
// Constants, tables and helpers for the arc odometry pose update
`default_nettype none

package aopu_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int POSE_WIDTH   = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORD_ITER    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CORD_CNT_W   = (CORD_ITER > 1) ? $clog2(CORD_ITER) : 1;

    localparam int IN_W       = 88;
    localparam int OUT_W      = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_TRUST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_OFFSET  = 3'd4;

    localparam logic [29:0] RAD_TO_TURN_Q16 = 30'd683565276;
    localparam logic [32:0] PI_Q30          = 33'd3373259426;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;

    localparam logic [29:0] ATAN_TBL [ATAN_ENTRIES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
    };

    // Horner divisors of the sin(u)/u series and floor(2^32 / d)
    localparam logic [6:0]  DIVISOR_TBL [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [29:0] RECIP_TBL   [4] = '{
        30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882
    };

    function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + 68'sd536870912;
        return t[67:30];
    endfunction

    function automatic logic signed [POSE_WIDTH-1:0] sat_pose(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = (68'sd1 <<< (POSE_WIDTH - 1)) - 68'sd1;
        lo = -hi - 68'sd1;
        if (v > hi)
        begin
            return POSE_WIDTH'(hi);
        end
        else if (v < lo)
        begin
            return POSE_WIDTH'(lo);
        end
        return POSE_WIDTH'(v);
    endfunction

endpackage

`default_nettype wire

[design/arc_odometry_pose_update.sv]
// Arc odometry pose update: shared multiplier, divider and CORDIC under one sequencer
// Sequence: turn magnitude, 16 divider steps, optional gyro blend, sin(u)/u series,
//   CORDIC_STEPS rotation steps, then multiply, round and pose update steps; the divider
//   is skipped with zero track width or turn overflow.
// One transaction at a time: s_tready is high only in idle; the last step stalls on a full output.
// Reset (rst_n low, async): pose and heading cleared, registers to their reset values.
`default_nettype none

module arc_odometry_pose_update (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // delta_left[23:0], delta_right[47:24], delta_side[71:48], gyro_delta[87:72]
    input  wire logic [aopu_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // pose_x[31:0], pose_y[63:32], pose_heading[79:64]
    output logic [aopu_pkg::OUT_W-1:0]       m_tdata,
    input  wire logic                        cfg_wr_en,
    input  wire logic [aopu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [aopu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aopu_pkg::*;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_MAG      = 5'd1;
    localparam logic [4:0] ST_DIV_INIT = 5'd2;
    localparam logic [4:0] ST_DIV      = 5'd3;
    localparam logic [4:0] ST_TURN     = 5'd4;
    localparam logic [4:0] ST_BL1      = 5'd5;
    localparam logic [4:0] ST_BL2      = 5'd6;
    localparam logic [4:0] ST_BL3      = 5'd7;
    localparam logic [4:0] ST_U        = 5'd8;
    localparam logic [4:0] ST_U_RND    = 5'd9;
    localparam logic [4:0] ST_W        = 5'd10;
    localparam logic [4:0] ST_W_RND    = 5'd11;
    localparam logic [4:0] ST_H_MUL    = 5'd12;
    localparam logic [4:0] ST_H_RND    = 5'd13;
    localparam logic [4:0] ST_H_REC    = 5'd14;
    localparam logic [4:0] ST_H_FIX    = 5'd15;
    localparam logic [4:0] ST_SQ       = 5'd16;
    localparam logic [4:0] ST_SQ_RND   = 5'd17;
    localparam logic [4:0] ST_LX2      = 5'd18;
    localparam logic [4:0] ST_LX3      = 5'd19;
    localparam logic [4:0] ST_LY2      = 5'd20;
    localparam logic [4:0] ST_LY3      = 5'd21;
    localparam logic [4:0] ST_C_INIT   = 5'd22;
    localparam logic [4:0] ST_C_ITER   = 5'd23;
    localparam logic [4:0] ST_C_END    = 5'd24;
    localparam logic [4:0] ST_X1       = 5'd25;
    localparam logic [4:0] ST_X2       = 5'd26;
    localparam logic [4:0] ST_X3       = 5'd27;
    localparam logic [4:0] ST_Y2       = 5'd28;
    localparam logic [4:0] ST_Y3       = 5'd29;

    // control state
    logic [4:0]  state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic signed [POSE_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POSE_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic [15:0] heading_reg, heading_next;
    logic        gyro_enable_reg;
    logic [8:0]  gyro_trust_reg;
    logic [15:0] left_offset_reg;
    logic [15:0] right_offset_reg;
    logic signed [16:0] side_offset_reg;

    // datapath
    logic signed [23:0] dl_reg, dl_next;
    logic signed [23:0] dr_reg, dr_next;
    logic signed [23:0] ds_reg, ds_next;
    logic signed [15:0] g_reg, g_next;
    logic        diff_neg_reg, diff_neg_next;
    logic        q_ovf_reg, q_ovf_next;
    logic [55:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic signed [15:0] turn_reg, turn_next;
    logic signed [67:0] acc_reg, acc_next;
    logic signed [67:0] prod_reg;
    logic signed [31:0] u_reg, u_next;
    logic [31:0] w_reg, w_next;
    logic [31:0] x_reg, x_next;
    logic signed [31:0] p_reg, p_next;
    logic [1:0]  hk_reg, hk_next;
    logic signed [31:0] sinq_reg, sinq_next;
    logic signed [33:0] lx_reg, lx_next;
    logic signed [33:0] ly_reg, ly_next;
    logic signed [33:0] cx_reg, cx_next;
    logic signed [33:0] cy_reg, cy_next;
    logic signed [33:0] z_reg, z_next;
    logic        flip_reg, flip_next;
    logic [CORD_CNT_W-1:0] cord_cnt_reg, cord_cnt_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;

    logic signed [24:0] diff;
    logic [24:0] mag;
    logic [16:0] w_sum;
    logic [55:0] rem_init;
    logic [55:0] div_den;
    logic [8:0]  t_eff;
    logic [8:0]  t_inv;
    logic [31:0] q0;
    logic [31:0] qd;
    logic [31:0] rr;
    logic [31:0] q_fix;
    logic signed [67:0] bl_sum;
    logic [31:0] mid;
    logic signed [33:0] z0;
    logic signed [33:0] tx;
    logic signed [33:0] ty;
    logic signed [67:0] pose_sum;
    logic signed [POSE_WIDTH-1:0] pos_y_sat;
    logic signed [63:0] px_ext;
    logic signed [63:0] py_ext;
    logic        out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign mul_p    = mul_a * mul_b;
    assign out_free = !m_tvalid_reg || m_tready;

    assign diff     = 25'(dl_reg) - 25'(dr_reg);
    assign mag      = diff[24] ? 25'(-diff) : 25'(diff);
    assign w_sum    = 17'(left_offset_reg) + 17'(right_offset_reg);
    assign rem_init = 56'(prod_reg[53:0]) + 56'({w_sum, 15'b0});
    assign div_den  = 56'({w_sum, 16'b0}) << cnt_reg;
    assign t_eff    = gyro_trust_reg[8] ? 9'd256 : gyro_trust_reg;
    assign t_inv    = 9'(10'd256 - 10'(t_eff));
    assign q0       = prod_reg[63:32];
    assign qd       = 32'(q0 * DIVISOR_TBL[hk_reg]);
    assign rr       = x_reg - qd;
    assign q_fix    = (rr >= 32'(DIVISOR_TBL[hk_reg])) ? q0 + 32'd1 : q0;
    assign bl_sum   = acc_reg + prod_reg + 68'sd128;
    assign mid      = {heading_reg, 16'b0} + {turn_reg[15], turn_reg, 15'b0};
    assign z0       = 34'(signed'(mid));
    assign tx       = cx_reg >>> cord_cnt_reg;
    assign ty       = cy_reg >>> cord_cnt_reg;
    assign px_ext   = 64'(pos_x_reg);
    assign py_ext   = 64'(pos_y_sat);

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        heading_next  = heading_reg;
        dl_next       = dl_reg;
        dr_next       = dr_reg;
        ds_next       = ds_reg;
        g_next        = g_reg;
        diff_neg_next = diff_neg_reg;
        q_ovf_next    = q_ovf_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        turn_next     = turn_reg;
        acc_next      = acc_reg;
        u_next        = u_reg;
        w_next        = w_reg;
        x_next        = x_reg;
        p_next        = p_reg;
        hk_next       = hk_reg;
        sinq_next     = sinq_reg;
        lx_next       = lx_reg;
        ly_next       = ly_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        z_next        = z_reg;
        flip_next     = flip_reg;
        cord_cnt_next = cord_cnt_reg;
        m_data_next   = m_data_reg;
        mul_a         = '0;
        mul_b         = '0;
        pose_sum      = '0;
        pos_y_sat     = pos_y_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dl_next    = s_tdata[23:0];
                    dr_next    = s_tdata[47:24];
                    ds_next    = s_tdata[71:48];
                    g_next     = s_tdata[87:72];
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                diff_neg_next = diff[24];
                mul_a         = 34'(mag);
                mul_b         = 34'(RAD_TO_TURN_Q16);
                state_next    = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                rem_next   = rem_init;
                q_next     = '0;
                q_ovf_next = 1'b0;
                cnt_next   = 4'd15;
                if (w_sum == '0)
                begin
                    state_next = ST_TURN;
                end
                else if (rem_init >= 56'({w_sum, 32'b0}))
                begin
                    q_ovf_next = 1'b1;
                    state_next = ST_TURN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= div_den)
                begin
                    rem_next       = rem_reg - div_den;
                    q_next[cnt_reg] = 1'b1;
                end
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = ST_TURN;
                end
            end
            ST_TURN:
            begin
                if (diff_neg_reg)
                begin
                    turn_next = (q_ovf_reg || q_reg > 16'd32768) ? -16'sd32768
                                                                 : 16'(-q_reg);
                end
                else
                begin
                    turn_next = (q_ovf_reg || q_reg > 16'd32767) ? 16'sd32767
                                                                 : signed'(q_reg);
                end
                state_next = gyro_enable_reg ? ST_BL1 : ST_U;
            end
            ST_BL1:
            begin
                mul_a      = 34'(t_eff);
                mul_b      = 34'(g_reg);
                state_next = ST_BL2;
            end
            ST_BL2:
            begin
                acc_next   = prod_reg;
                mul_a      = 34'(t_inv);
                mul_b      = 34'(turn_reg);
                state_next = ST_BL3;
            end
            ST_BL3:
            begin
                turn_next  = bl_sum[23:8];
                state_next = ST_U;
            end
            ST_U:
            begin
                mul_a      = 34'(turn_reg);
                mul_b      = 34'(PI_Q30);
                state_next = ST_U_RND;
            end
            ST_U_RND:
            begin
                acc_next   = prod_reg + 68'sd32768;
                u_next     = acc_next[47:16];
                state_next = ST_W;
            end
            ST_W:
            begin
                mul_a      = 34'(u_reg);
                mul_b      = 34'(u_reg);
                state_next = ST_W_RND;
            end
            ST_W_RND:
            begin
                w_next     = 32'(rnd30(prod_reg));
                x_next     = 32'(rnd30(prod_reg));
                hk_next    = 2'd0;
                state_next = ST_H_REC;
            end
            ST_H_MUL:
            begin
                mul_a      = 34'(w_reg);
                mul_b      = 34'(p_reg);
                state_next = ST_H_RND;
            end
            ST_H_RND:
            begin
                x_next     = 32'(rnd30(prod_reg));
                state_next = ST_H_REC;
            end
            ST_H_REC:
            begin
                mul_a      = 34'(x_reg);
                mul_b      = 34'(RECIP_TBL[hk_reg]);
                state_next = ST_H_FIX;
            end
            ST_H_FIX:
            begin
                p_next = Q30_ONE - signed'(q_fix);
                if (hk_reg == 2'd3)
                begin
                    state_next = ST_SQ;
                end
                else
                begin
                    hk_next    = hk_reg + 2'd1;
                    state_next = ST_H_MUL;
                end
            end
            ST_SQ:
            begin
                mul_a      = 34'(u_reg);
                mul_b      = 34'(p_reg);
                state_next = ST_SQ_RND;
            end
            ST_SQ_RND:
            begin
                sinq_next  = 32'(rnd30(prod_reg));
                mul_a      = 34'(ds_reg);
                mul_b      = 34'(p_reg);
                state_next = ST_LX2;
            end
            ST_LX2:
            begin
                acc_next   = prod_reg;
                mul_a      = 34'(sinq_reg);
                mul_b      = 34'(side_offset_reg);
                state_next = ST_LX3;
            end
            ST_LX3:
            begin
                lx_next    = 34'(rnd30(acc_reg + (prod_reg <<< 1)));
                mul_a      = 34'(dr_reg);
                mul_b      = 34'(p_reg);
                state_next = ST_LY2;
            end
            ST_LY2:
            begin
                acc_next   = prod_reg;
                mul_a      = 34'(sinq_reg);
                mul_b      = 34'(right_offset_reg);
                state_next = ST_LY3;
            end
            ST_LY3:
            begin
                ly_next    = 34'(rnd30(acc_reg + (prod_reg <<< 1)));
                state_next = ST_C_INIT;
            end
            ST_C_INIT:
            begin
                flip_next     = 1'b0;
                z_next        = z0;
                if (z0 > 34'sd1073741824)
                begin
                    z_next    = z0 - 34'sd2147483648;
                    flip_next = 1'b1;
                end
                else if (z0 < -34'sd1073741824)
                begin
                    z_next    = z0 + 34'sd2147483648;
                    flip_next = 1'b1;
                end
                cx_next       = 34'(CORDIC_GAIN_Q30);
                cy_next       = '0;
                cord_cnt_next = '0;
                state_next    = ST_C_ITER;
            end
            ST_C_ITER:
            begin
                if (z_reg >= 0)
                begin
                    cx_next = cx_reg - ty;
                    cy_next = cy_reg + tx;
                    z_next  = z_reg - 34'(ATAN_TBL[5'(cord_cnt_reg)]);
                end
                else
                begin
                    cx_next = cx_reg + ty;
                    cy_next = cy_reg - tx;
                    z_next  = z_reg + 34'(ATAN_TBL[5'(cord_cnt_reg)]);
                end
                cord_cnt_next = cord_cnt_reg + 1'b1;
                if (cord_cnt_reg == CORD_CNT_W'(CORD_ITER - 1))
                begin
                    state_next = ST_C_END;
                end
            end
            ST_C_END:
            begin
                if (flip_reg)
                begin
                    cx_next = -cx_reg;
                    cy_next = -cy_reg;
                end
                state_next = ST_X1;
            end
            ST_X1:
            begin
                mul_a      = lx_reg;
                mul_b      = cx_reg;
                state_next = ST_X2;
            end
            ST_X2:
            begin
                acc_next   = prod_reg;
                mul_a      = ly_reg;
                mul_b      = cy_reg;
                state_next = ST_X3;
            end
            ST_X3:
            begin
                pose_sum   = 68'(pos_x_reg) + 68'(rnd30(acc_reg + prod_reg));
                pos_x_next = sat_pose(pose_sum);
                mul_a      = ly_reg;
                mul_b      = cx_reg;
                state_next = ST_Y2;
            end
            ST_Y2:
            begin
                acc_next   = prod_reg;
                mul_a      = lx_reg;
                mul_b      = cy_reg;
                state_next = ST_Y3;
            end
            ST_Y3:
            begin
                // operands repeated so the product holds through an output stall
                mul_a     = lx_reg;
                mul_b     = cy_reg;
                pose_sum  = 68'(pos_y_reg) + 68'(rnd30(acc_reg - prod_reg));
                pos_y_sat = sat_pose(pose_sum);
                if (out_free)
                begin
                    pos_y_next    = pos_y_sat;
                    heading_next  = heading_reg + unsigned'(turn_reg);
                    m_data_next   = {heading_reg + unsigned'(turn_reg),
                                     py_ext[31:0], px_ext[31:0]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            heading_reg      <= '0;
            gyro_enable_reg  <= 1'b0;
            gyro_trust_reg   <= '0;
            left_offset_reg  <= 16'd24576;
            right_offset_reg <= 16'd24576;
            side_offset_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            heading_reg  <= heading_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_GYRO_ENABLE:  gyro_enable_reg  <= cfg_data[0];
                    REG_GYRO_TRUST:   gyro_trust_reg   <= cfg_data[8:0];
                    REG_LEFT_OFFSET:  left_offset_reg  <= cfg_data[15:0];
                    REG_RIGHT_OFFSET: right_offset_reg <= cfg_data[15:0];
                    REG_SIDE_OFFSET:  side_offset_reg  <= signed'(cfg_data[16:0]);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg       <= dl_next;
        dr_reg       <= dr_next;
        ds_reg       <= ds_next;
        g_reg        <= g_next;
        diff_neg_reg <= diff_neg_next;
        q_ovf_reg    <= q_ovf_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        turn_reg     <= turn_next;
        acc_reg      <= acc_next;
        prod_reg     <= mul_p;
        u_reg        <= u_next;
        w_reg        <= w_next;
        x_reg        <= x_next;
        p_reg        <= p_next;
        hk_reg       <= hk_next;
        sinq_reg     <= sinq_next;
        lx_reg       <= lx_next;
        ly_reg       <= ly_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        z_reg        <= z_next;
        flip_reg     <= flip_next;
        cord_cnt_reg <= cord_cnt_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire

[design/aopu_checker.sv]
// Port-level checker for the arc odometry pose update, bound to the top level
`default_nettype none
`include "arc_odometry_pose_update_defines.svh"

module aopu_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [aopu_pkg::OUT_W-1:0] m_tdata
);

    `AOPU_ASSERT_RST(a_reset_no_result, !rst_n |-> !m_tvalid, "result valid in reset")
    `AOPU_ASSERT(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `AOPU_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready while busy")
    `AOPU_ASSERT(a_no_early_result, s_tvalid && s_tready |=> !$rose(m_tvalid), "result too early")

endmodule

bind arc_odometry_pose_update aopu_checker u_aopu_checker (.*);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the arc odometry pose update block
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic signed [23:0] dl;
        logic signed [23:0] dr;
        logic signed [23:0] ds;
        logic signed [15:0] gy;
        bit                 known;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [15:0]        h;
    } stim_row_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] h;
    } pose_t;

    localparam longint RAD_TO_TURN = 64'sd683565276;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam int     CYCLE_LIMIT = 1000000;

    localparam longint ATAN_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [aopu_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [aopu_pkg::OUT_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [aopu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [aopu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and register copy
    bit                 gyro_en;
    bit [8:0]           gyro_wt;
    bit [15:0]          left_off;
    bit [15:0]          right_off;
    logic signed [16:0] side_off;
    longint             pos_x;
    longint             pos_y;
    bit [15:0]          hdg;

    pose_t  pending_poses[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     no_idle = 1'b0;
    bit     hold_req = 1'b0;

    arc_odometry_pose_update DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic longint rnd_sh(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint turn_from_wheels(input longint diff);
        longint wd;
        longint mag;
        longint den;
        longint q;
        wd = longint'(left_off) + longint'(right_off);
        if (wd == 0 || diff == 0)
        begin
            return 0;
        end
        mag = (diff < 0) ? -diff : diff;
        den = wd <<< 16;
        q = (mag * RAD_TO_TURN + den / 2) / den;
        if (diff < 0)
        begin
            return (q > 32768) ? -64'sd32768 : -q;
        end
        return (q > 32767) ? 64'sd32767 : q;
    endfunction

    function automatic pose_t advance_pose(input logic signed [23:0] dl,
                                           input logic signed [23:0] dr,
                                           input logic signed [23:0] ds,
                                           input logic signed [15:0] gy);
        longint turn;
        longint wt;
        longint u;
        longint w;
        longint p;
        longint f;
        longint sinq;
        longint lx;
        longint ly;
        longint z;
        longint cx;
        longint cy;
        longint tx;
        longint ty;
        bit [31:0] mid;
        bit flip;
        pose_t r;
        turn = turn_from_wheels(longint'(dl) - longint'(dr));
        if (gyro_en)
        begin
            wt = (gyro_wt > 256) ? 256 : longint'(gyro_wt);
            turn = rnd_sh(wt * longint'(gy) + (256 - wt) * turn, 8);
        end
        u = rnd_sh(turn * PI_Q30, 16);
        w = rnd_sh(u * u, 30);
        p = ONE_Q30 - w / 72;
        p = ONE_Q30 - rnd_sh(w * p, 30) / 42;
        p = ONE_Q30 - rnd_sh(w * p, 30) / 20;
        f = ONE_Q30 - rnd_sh(w * p, 30) / 6;
        sinq = rnd_sh(u * f, 30);
        lx = rnd_sh(longint'(ds) * f + 2 * sinq * longint'(side_off), 30);
        ly = rnd_sh(longint'(dr) * f + 2 * sinq * longint'(right_off), 30);
        mid = 32'((longint'(hdg) <<< 16) + turn * 32768);
        z = longint'({32'b0, mid});
        flip = 1'b0;
        if (z >= 64'sd2147483648)
        begin
            z = z - 64'sd4294967296;
        end
        if (z > 64'sd1073741824)
        begin
            z = z - 64'sd2147483648;
            flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z = z + 64'sd2147483648;
            flip = 1'b1;
        end
        cx = GAIN_Q30;
        cy = 0;
        for (int i = 0; i < aopu_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            tx = cx >>> i;
            ty = cy >>> i;
            if (z >= 0)
            begin
                cx = cx - ty;
                cy = cy + tx;
                z = z - ATAN_TURN[i];
            end
            else
            begin
                cx = cx + ty;
                cy = cy - tx;
                z = z + ATAN_TURN[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        pos_x = sat32(pos_x + rnd_sh(lx * cx + ly * cy, 30));
        pos_y = sat32(pos_y + rnd_sh(ly * cx - lx * cy, 30));
        hdg = 16'(longint'(hdg) + turn);
        r.x = 32'(pos_x);
        r.y = 32'(pos_y);
        r.h = hdg;
        return r;
    endfunction

    // one input transaction; valid stays high when the next one follows at once
    task automatic send_delta(input logic signed [23:0] dl, input logic signed [23:0] dr,
                              input logic signed [23:0] ds, input logic signed [15:0] gy,
                              input bit known, input pose_t typed);
        int gap;
        pose_t pr;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {gy, ds, dr, dl};
        do
            @(posedge clk);
        while (!s_tready);
        pr = advance_pose(dl, dr, ds, gy);
        pending_poses.push_back(known ? typed : pr);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [aopu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [aopu_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            aopu_pkg::REG_GYRO_ENABLE:  gyro_en = val[0];
            aopu_pkg::REG_GYRO_TRUST:   gyro_wt = val[8:0];
            aopu_pkg::REG_LEFT_OFFSET:  left_off = val[15:0];
            aopu_pkg::REG_RIGHT_OFFSET: right_off = val[15:0];
            aopu_pkg::REG_SIDE_OFFSET:  side_off = val[16:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input bit en, input bit [8:0] wt, input bit [15:0] lo,
                               input bit [15:0] ro, input logic [16:0] so);
        wait_idle();
        write_reg(aopu_pkg::REG_GYRO_ENABLE, 17'(en));
        write_reg(aopu_pkg::REG_GYRO_TRUST, 17'(wt));
        write_reg(aopu_pkg::REG_LEFT_OFFSET, 17'(lo));
        write_reg(aopu_pkg::REG_RIGHT_OFFSET, 17'(ro));
        write_reg(aopu_pkg::REG_SIDE_OFFSET, so);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [23:0] draw_delta();
        if ($urandom_range(0, 3) != 0)
        begin
            return 24'($signed($urandom_range(0, 16000)) - 8000);
        end
        return 24'($urandom);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                n = 600;
            end
            else
            begin
                n = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h h=%h",
                             m_tdata[31:0], m_tdata[63:32], m_tdata[79:64]);
            end
            else
            begin
                e = pending_poses.pop_front();
                if (m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y
                    || m_tdata[79:64] !== e.h)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pose mismatch: exp x=%h y=%h h=%h got x=%h y=%h h=%h",
                                 e.x, e.y, e.h,
                                 m_tdata[31:0], m_tdata[63:32], m_tdata[79:64]);
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows[10];
        pose_t typed;
        rst_n <= 1'b0;
        gyro_en = 1'b0;
        gyro_wt = '0;
        left_off = 16'd24576;
        right_off = 16'd24576;
        side_off = '0;
        pos_x = 0;
        pos_y = 0;
        hdg = '0;
        rows[0] = '{24'sd0, 24'sd0, 24'sd0, 16'sd0, 1'b1, 32'd0, 32'd0, 16'd0};
        rows[1] = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 1'b0, '0, '0, '0};
        rows[2] = '{24'h800000, 24'h800000, 24'h800000, 16'h8000, 1'b0, '0, '0, '0};
        rows[3] = '{24'h7FFFFF, 24'h800000, 24'sd4096, 16'h7FFF, 1'b0, '0, '0, '0};
        rows[4] = '{24'h800000, 24'h7FFFFF, -24'sd4096, 16'h8000, 1'b0, '0, '0, '0};
        rows[5] = '{24'sd4096, -24'sd4096, 24'sd1000, 16'sd0, 1'b0, '0, '0, '0};
        rows[6] = '{24'sd1, 24'sd0, 24'sd0, 16'sd1, 1'b0, '0, '0, '0};
        rows[7] = '{24'sd8192, 24'sd8192, -24'sd300, -16'sd1, 1'b0, '0, '0, '0};
        rows[8] = '{24'hFFFFFF, 24'sd0, 24'hFFFFFF, 16'hFFFF, 1'b0, '0, '0, '0};
        rows[9] = '{24'h555555, 24'hAAAAAA, 24'h5A5A5A, 16'hA5A5, 1'b0, '0, '0, '0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
                load_config(1'b1, 9'd256, 16'd24576, 16'd24576, 17'd4096);
            foreach (rows[i])
            begin
                typed = '{rows[i].x, rows[i].y, rows[i].h};
                send_delta(rows[i].dl, rows[i].dr, rows[i].ds, rows[i].gy,
                           rows[i].known && pass == 0, typed);
            end
        end

        // drive the pose into saturation both ways
        load_config(1'b0, 9'd0, 16'd24576, 16'd24576, 17'd0);
        for (int i = 0; i < 800; i++)
            send_delta(24'sd0, 24'sd0, (i < 280) ? 24'h7FFFFF : 24'h800000, 16'sd0,
                       1'b0, typed);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_config(1'b1, 9'd128, 16'd24576, 16'd24576, 17'd0);
                1: load_config(1'b1, 9'd511, 16'd1, 16'd1, 17'h10000);
                2: load_config(1'b0, 9'd0, 16'd65535, 16'd65535, 17'h0FFFF);
                3: load_config(1'b1, 9'd0, 16'd0, 16'd0, 17'd100);
                default: load_config(1'($urandom), 9'($urandom_range(0, 511)),
                                     16'($urandom), 16'($urandom), 17'($urandom));
            endcase
            no_idle = (ph == 3 || ph == 6);
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < 110; i++)
                send_delta(draw_delta(), draw_delta(), draw_delta(),
                           ($urandom_range(0, 3) != 0) ? 16'($signed($urandom_range(0, 4000)) - 2000)
                                                       : 16'($urandom),
                           1'b0, typed);
        end
        no_idle = 1'b0;

        wait_idle();
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/aopu_pkg.sv
design/arc_odometry_pose_update.sv
design/aopu_checker.sv
sim/tb.sv
